// ===== design/lowpass_feedback_comb_filter_unit_defines.svh =====
// Assertion macros shared by the comb filter modules.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef LOWPASS_FEEDBACK_COMB_FILTER_UNIT_DEFINES_SVH
`define LOWPASS_FEEDBACK_COMB_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define LFCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define LFCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lfcf_pkg.sv =====
// Shared types, constants and microcode for the lowpass feedback comb filter.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lfcf_pkg;

    // Default delay line depth.
    localparam int MAX_DELAY = 4096;

    // Fixed-point constants: Q25 gains, round half up before the shift.
    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 26;
    localparam int LENGTH_W   = 13;
    localparam int COEF_W     = GAIN_W + 1;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int Q_SHIFT    = 25;
    localparam logic [GAIN_W-1:0] Q_ONE = GAIN_W'(26'h2000000);
    localparam logic [Q_SHIFT+SAMPLE_W-1:0] ROUND_HALF = (Q_SHIFT + SAMPLE_W)'(32'h1000000);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DAMP     = 2'd0,
        CFG_FEEDBACK = 2'd1,
        CFG_LENGTH   = 2'd2
    } cfg_idx_t;

    // Microcode step addresses.
    typedef enum logic [2:0] {
        STEP_ACCEPT   = 3'd0,
        STEP_LOWPASS  = 3'd1,
        STEP_STORE    = 3'd2,
        STEP_FEEDBACK = 3'd3,
        STEP_COMMIT   = 3'd4
    } step_t;

    // Multiplier operand selects.
    typedef enum logic {
        A_STORE   = 1'b0,
        A_DELAYED = 1'b1
    } asel_t;

    typedef enum logic [1:0] {
        B_DAMP     = 2'd0,
        B_UNDAMP   = 2'd1,
        B_FEEDBACK = 2'd2
    } bsel_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic  wait_in;     // hold here until an input transfer
        logic  wait_out;    // hold here while the output register is blocked
        logic  start;       // latch the sample and issue the delay line read
        logic  mul_en;      // load the product register
        asel_t a_sel;
        bsel_t b_sel;
        logic  acc_en;      // keep the rounded damped product
        logic  delayed_en;  // keep the delayed sample
        logic  store_en;    // update the lowpass store
        logic  commit;      // write back, present result, advance index
        step_t seq_next;    // jump target when not holding
    } ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic out_blocked;
    } stat_t;

    // Microprogram ROM.
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '0;
        w.a_sel = A_STORE;
        w.b_sel = B_DAMP;
        w.seq_next = STEP_ACCEPT;
        case (step)
            STEP_ACCEPT:
            begin
                w.wait_in  = 1'b1;
                w.start    = 1'b1;
                w.mul_en   = 1'b1;
                w.a_sel    = A_STORE;
                w.b_sel    = B_DAMP;
                w.seq_next = STEP_LOWPASS;
            end
            STEP_LOWPASS:
            begin
                w.acc_en     = 1'b1;
                w.delayed_en = 1'b1;
                w.mul_en     = 1'b1;
                w.a_sel      = A_DELAYED;
                w.b_sel      = B_UNDAMP;
                w.seq_next   = STEP_STORE;
            end
            STEP_STORE:
            begin
                w.store_en = 1'b1;
                w.seq_next = STEP_FEEDBACK;
            end
            STEP_FEEDBACK:
            begin
                w.mul_en   = 1'b1;
                w.a_sel    = A_STORE;
                w.b_sel    = B_FEEDBACK;
                w.seq_next = STEP_COMMIT;
            end
            STEP_COMMIT:
            begin
                w.wait_out = 1'b1;
                w.commit   = 1'b1;
                w.seq_next = STEP_ACCEPT;
            end
            default:
            begin
                w.seq_next = STEP_ACCEPT;
            end
        endcase
        return w;
    endfunction

    // Q25 rounding: add one half, shift right by 25, keep the low 32 bits.
    function automatic logic [SAMPLE_W-1:0] qround(input logic signed [PROD_W-1:0] p);
        logic [Q_SHIFT+SAMPLE_W-1:0] sum;
        sum = p[Q_SHIFT+SAMPLE_W-1:0] + ROUND_HALF;
        return sum[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
    endfunction

endpackage

// ===== design/lfcf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module lfcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lfcf_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional holds.
// Depends on lfcf_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "lowpass_feedback_comb_filter_unit_defines.svh"

module lfcf_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lfcf_pkg::stat_t stat,
    output lfcf_pkg::ctrl_t ctrl
);

    lfcf_pkg::step_t step_reg;
    lfcf_pkg::step_t step_next;
    logic            hold;

    // Control word for the current step.
    always_comb
    begin
        ctrl = lfcf_pkg::ucode_rom(step_reg);
    end

    // Input is taken only in the step that waits for it.
    assign in_stall = !ctrl.wait_in;

    // Next step: hold on an unmet wait, otherwise follow the jump field.
    always_comb
    begin
        hold = (ctrl.wait_in && !in_valid) || (ctrl.wait_out && stat.out_blocked);
        if (hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = ctrl.seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lfcf_pkg::STEP_ACCEPT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // A transfer in always starts the lowpass step next.
    `LFCF_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, step_reg == lfcf_pkg::STEP_LOWPASS, "input transfer did not start the program")
    // A blocked commit holds its step.
    `LFCF_ASSERT_NEXT(a_commit_holds, ctrl.commit && stat.out_blocked, step_reg == lfcf_pkg::STEP_COMMIT, "commit step left while output blocked")

endmodule

// ===== design/lfcf_dp.sv =====
// Datapath: shared multiplier, lowpass store, delay line, index and output register.
// Depends on lfcf_pkg, lfcf_ram and the shared assertion macros.
`timescale 1ns / 1ps
`include "lowpass_feedback_comb_filter_unit_defines.svh"

module lfcf_dp #(
    parameter int MAX_DELAY = lfcf_pkg::MAX_DELAY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lfcf_pkg::ctrl_t                      ctrl,
    output lfcf_pkg::stat_t                      stat,
    input  logic signed [lfcf_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lfcf_pkg::SAMPLE_W-1:0] sample_out,
    input  logic [lfcf_pkg::GAIN_W-1:0]          damp_gain,
    input  logic [lfcf_pkg::GAIN_W-1:0]          feedback_gain,
    input  logic [lfcf_pkg::LENGTH_W-1:0]        delay_length
);

    localparam int IDX_W  = MAX_DELAY > 1 ? $clog2(MAX_DELAY) : 1;
    localparam int FILL_W = $clog2(MAX_DELAY + 1);
    localparam int CMP_W  = FILL_W > lfcf_pkg::LENGTH_W ? FILL_W : lfcf_pkg::LENGTH_W;
    localparam int SW     = lfcf_pkg::SAMPLE_W;
    localparam int CW     = lfcf_pkg::COEF_W;
    localparam int PW     = lfcf_pkg::PROD_W;

    logic [SW-1:0]        sample_reg;
    logic [SW-1:0]        delayed_reg;
    logic [SW-1:0]        acc_reg;
    logic [SW-1:0]        store_reg;
    logic [SW-1:0]        store_next;
    logic signed [PW-1:0] prod_reg;
    logic [SW-1:0]        out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    logic [SW-1:0]        ram_q;
    logic [SW-1:0]        delayed_masked;
    logic [SW-1:0]        wb_data;
    logic signed [SW-1:0] op_a;
    logic signed [CW-1:0] op_b;
    logic signed [CW-1:0] undamp;
    logic [CMP_W-1:0]     len_ext;
    logic [CMP_W-1:0]     len_sat;
    logic [CMP_W-1:0]     idx_inc;

    // Delay line storage.
    lfcf_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_DELAY)
    ) u_delay_ram (
        .clk  (clk),
        .we   (ctrl.commit && !stat.out_blocked),
        .waddr(idx_reg),
        .wdata(wb_data),
        .re   (ctrl.start),
        .raddr(idx_reg),
        .rdata(ram_q)
    );

    // Entries at or past the fill count were never written and read as zero.
    assign delayed_masked = rd_valid_reg ? ram_q : '0;

    // Multiplier operands; the undamped weight may go negative.
    assign undamp = $signed({1'b0, lfcf_pkg::Q_ONE}) - $signed({1'b0, damp_gain});

    always_comb
    begin
        case (ctrl.a_sel)
            lfcf_pkg::A_STORE:   op_a = store_reg;
            lfcf_pkg::A_DELAYED: op_a = delayed_masked;
            default:             op_a = store_reg;
        endcase
        case (ctrl.b_sel)
            lfcf_pkg::B_DAMP:     op_b = $signed({1'b0, damp_gain});
            lfcf_pkg::B_UNDAMP:   op_b = undamp;
            lfcf_pkg::B_FEEDBACK: op_b = $signed({1'b0, feedback_gain});
            default:              op_b = '0;
        endcase
    end

    // New store is the sum of the two rounded products.
    assign store_next = acc_reg + lfcf_pkg::qround(prod_reg);
    assign wb_data    = sample_reg + lfcf_pkg::qround(prod_reg);

    // Index advance with the length saturated to the delay line depth.
    always_comb
    begin
        len_ext = CMP_W'(delay_length);
        if (len_ext > CMP_W'(MAX_DELAY))
        begin
            len_sat = CMP_W'(MAX_DELAY);
        end
        else
        begin
            len_sat = len_ext;
        end
        idx_inc = CMP_W'(idx_reg) + CMP_W'(1);
        idx_next = idx_reg;
        fill_next = fill_reg;
        if (ctrl.commit && !stat.out_blocked)
        begin
            if (idx_inc >= len_sat)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_inc[IDX_W-1:0];
            end
            if (CMP_W'(idx_reg) == CMP_W'(fill_reg))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    // Output register: loaded on commit, held while stalled.
    assign stat.out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        if (ctrl.commit && !stat.out_blocked)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = stat.out_blocked;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            fill_reg      <= '0;
            store_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (ctrl.store_en)
            begin
                store_reg <= store_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sample_reg   <= sample_in;
            rd_valid_reg <= CMP_W'(idx_reg) < CMP_W'(fill_reg);
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PW'(op_a * op_b);
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= lfcf_pkg::qround(prod_reg);
        end
        if (ctrl.delayed_en)
        begin
            delayed_reg <= delayed_masked;
        end
        if (ctrl.commit && !stat.out_blocked)
        begin
            out_reg <= delayed_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // The index never runs past the written prefix of the delay line.
    `LFCF_ASSERT_NOW(a_idx_in_fill, 1'b1, CMP_W'(idx_reg) <= CMP_W'(fill_reg), "write index beyond fill count")
    // A taken commit always presents a result.
    `LFCF_ASSERT_NEXT(a_commit_out, ctrl.commit && !stat.out_blocked, out_valid_reg, "commit did not present a result")

endmodule

// ===== design/lowpass_feedback_comb_filter_unit.sv =====
// Top level of the lowpass feedback comb filter: configuration registers and wiring.
// Depends on lfcf_pkg, lfcf_seq, lfcf_dp and lfcf_ram.
//
//   channel  signals                                    dir  transfer when
//   input    in_valid, in_stall, sample_in              in   in_valid && !in_stall
//   output   out_valid, out_stall, sample_out           out  out_valid && !out_stall
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  in   cfg_valid && cfg_ready
//
// Each sample runs a five-step microprogram; a new sample is taken only after the previous
// one commits, and the single shared multiplier is used in three of the steps.
// The next sample is taken while a finished result still waits in the output register.
// A stalled output holds the commit step, and with it the input, until the result moves.
// Reset clears the index, the fill count and the lowpass store; the delay line has no
// clearing pass, since entries past the fill count read as zero.
`timescale 1ns / 1ps

module lowpass_feedback_comb_filter_unit #(
    parameter int MAX_DELAY = lfcf_pkg::MAX_DELAY
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [lfcf_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [lfcf_pkg::SAMPLE_W-1:0]    sample_out,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lfcf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [lfcf_pkg::GAIN_W-1:0]             cfg_data
);

    logic [lfcf_pkg::GAIN_W-1:0]   damp_reg;
    logic [lfcf_pkg::GAIN_W-1:0]   feedback_reg;
    logic [lfcf_pkg::LENGTH_W-1:0] length_reg;
    lfcf_pkg::ctrl_t               ctrl;
    lfcf_pkg::stat_t               stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_reg     <= '0;
            feedback_reg <= '0;
            length_reg   <= lfcf_pkg::LENGTH_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lfcf_pkg::cfg_idx_t'(cfg_index))
                lfcf_pkg::CFG_DAMP:     damp_reg     <= cfg_data;
                lfcf_pkg::CFG_FEEDBACK: feedback_reg <= cfg_data;
                lfcf_pkg::CFG_LENGTH:   length_reg   <= cfg_data[lfcf_pkg::LENGTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Program sequencer.
    lfcf_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Datapath.
    lfcf_dp #(
        .MAX_DELAY(MAX_DELAY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .damp_gain    (damp_reg),
        .feedback_gain(feedback_reg),
        .delay_length (length_reg)
    );

endmodule

// ===== test/lowpass_feedback_comb_filter_unit_tb.sv =====
// Self-checking testbench for the lowpass feedback comb filter unit: a directed table,
// then random phases with random handshake gaps, checked against typed or predicted values.
// Depends on lfcf_pkg and the lowpass_feedback_comb_filter_unit RTL.
`timescale 1ns / 1ps

module lowpass_feedback_comb_filter_unit_tb;

    import lfcf_pkg::*;

    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          PLAN_ROWS     = 34;
    localparam int          RAND_PHASES   = 10;
    localparam int          PHASE_ITEMS   = 55;
    localparam int          SETTLE_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic
    {
        ROW_SAMPLE = 1'b0,
        ROW_WRITE  = 1'b1
    } row_kind_t;

    typedef struct
    {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  reg_sel;
        logic [SAMPLE_W-1:0]     value;
        bit                      typed;
        logic [SAMPLE_W-1:0]     want;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample_in = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [GAIN_W-1:0]           cfg_data = '0;

    // Predictor state: its own delay ring, lowpass accumulator and register copies.
    logic [SAMPLE_W-1:0]         ring_mem [MAX_DELAY];
    int unsigned                 ring_pos;
    logic [SAMPLE_W-1:0]         lp_acc;
    logic [GAIN_W-1:0]           gain_damp;
    logic [GAIN_W-1:0]           gain_fb;
    logic [LENGTH_W-1:0]         ring_len;

    logic [SAMPLE_W-1:0]         delayed_q [$];
    logic [SAMPLE_W-1:0]         want_sample;
    int                          fail_count = 0;
    int                          stall_left = 0;
    int                          cycle_count = 0;
    bit                          burst = 1'b0;
    stim_row_t                   plan [PLAN_ROWS];

    lowpass_feedback_comb_filter_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, delayed_q.size());
            $display("lowpass_feedback_comb_filter_unit_tb: FAIL");
            $finish;
        end
    end

    // Idle cycles before the next transfer on either side; zero in burst stretches.
    function automatic int draw_gap();
        if (burst)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Signed sample times signed Q25 gain, rounded half up, low 32 bits of the shifted sum.
    function automatic logic [SAMPLE_W-1:0] q25_scale(input logic [SAMPLE_W-1:0] a,
                                                      input logic signed [63:0] g);
        logic signed [63:0] prod;
        prod = $signed({{32{a[SAMPLE_W-1]}}, a}) * g;
        prod = prod + 64'sh1000000;
        return prod[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
    endfunction

    // Advance the predicted filter by one sample and return the delayed sample it reads.
    function automatic logic [SAMPLE_W-1:0] comb_predict(input logic [SAMPLE_W-1:0] x);
        int unsigned         span;
        int unsigned         pos;
        logic [SAMPLE_W-1:0] tap;
        logic signed [63:0]  damp;
        logic signed [63:0]  undamp;
        span = ring_len;
        if (span > MAX_DELAY)
            span = MAX_DELAY;
        pos = ring_pos;
        if (pos >= MAX_DELAY)
            pos = 0;
        damp   = $signed({38'd0, gain_damp});
        undamp = 64'sd33554432 - damp;
        tap    = ring_mem[pos];
        lp_acc = q25_scale(tap, undamp) + q25_scale(lp_acc, damp);
        ring_mem[pos] = x + q25_scale(lp_acc, $signed({38'd0, gain_fb}));
        pos = pos + 1;
        if (pos >= span)
            pos = 0;
        ring_pos = pos;
        return tap;
    endfunction

    // One configuration transfer; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DAMP:     gain_damp = data;
            CFG_FEEDBACK: gain_fb   = data;
            CFG_LENGTH:   ring_len  = data[LENGTH_W-1:0];
            default:      ;
        endcase
    endtask

    // Stop feeding and wait until every expected result has come out.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (delayed_q.size() != 0)
            @(posedge clk);
    endtask

    // One input transfer after a random gap; queue the typed or predicted result.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input logic [SAMPLE_W-1:0] want);
        int                  gap;
        logic [SAMPLE_W-1:0] predicted;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = comb_predict(s);
        delayed_q.push_back(typed ? want : predicted);
    endtask

    // Output side: random stall per result, compare each transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (delayed_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: sample_out=%h", sample_out);
                    fail_count++;
                end
                else
                begin
                    want_sample = delayed_q.pop_front();
                    if (sample_out !== want_sample)
                    begin
                        if (fail_count < 10)
                            $display("sample_out mismatch: expected %h, got %h",
                                     want_sample, sample_out);
                        fail_count++;
                    end
                end
                stall_left = draw_gap();
                out_stall <= (stall_left != 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // Stimulus: reset, directed table, randomized phases, drain and verdict.
    initial
    begin
        bit                     cfg_open;
        bit                     wrote;
        logic [GAIN_W-1:0]      data;
        logic [SAMPLE_W-1:0]    s;

        for (int i = 0; i < MAX_DELAY; i++)
            ring_mem[i] = '0;
        ring_pos  = 0;
        lp_acc    = '0;
        gain_damp = '0;
        gain_fb   = '0;
        ring_len  = 13'd1;

        // With reset settings the unit returns the previous sample, so the first
        // rows carry their expected values; later rows rely on the predictor.
        plan = '{
            '{ROW_SAMPLE, CFG_DAMP,     32'h7FFFFFFF, 1'b1, 32'h00000000},
            '{ROW_SAMPLE, CFG_DAMP,     32'h80000000, 1'b1, 32'h7FFFFFFF},
            '{ROW_SAMPLE, CFG_DAMP,     32'hFFFFFFFF, 1'b1, 32'h80000000},
            '{ROW_SAMPLE, CFG_DAMP,     32'h00000001, 1'b1, 32'hFFFFFFFF},
            '{ROW_SAMPLE, CFG_DAMP,     32'h00000000, 1'b1, 32'h00000001},
            '{ROW_WRITE,  CFG_DAMP,     32'h02000000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_FEEDBACK, 32'h02000000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_LENGTH,   32'h00000003, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h12345678, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h80000000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h7FFFFFFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'hDEADBEEF, 1'b0, 32'h0},
            // Damping above one and length beyond the delay line depth.
            '{ROW_WRITE,  CFG_DAMP,     32'h03FFFFFF, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_FEEDBACK, 32'h03FFFFFF, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_LENGTH,   32'h00001FFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h40000000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'hC0000000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h7FFFFFFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h80000001, 1'b0, 32'h0},
            // Length set equal to the current index, then lowered again.
            '{ROW_WRITE,  CFG_DAMP,     32'h01000000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_FEEDBACK, 32'h01800000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_LENGTH,   32'h00000005, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h00000100, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'hFFFFFF00, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h55555555, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'hAAAAAAAA, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_LENGTH,   32'h00000002, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h0F0F0F0F, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'hF0F0F0F0, 1'b0, 32'h0},
            // Length zero behaves as length one.
            '{ROW_WRITE,  CFG_LENGTH,   32'h00000000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h00000003, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'hFFFFFFFD, 1'b0, 32'h0},
            // A write to the unused index changes nothing.
            '{ROW_WRITE,  CFG_SPARE,    32'h03FFFFFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_DAMP,     32'h13579BDF, 1'b0, 32'h0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        cfg_open = 1'b0;
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                if (!cfg_open)
                    quiesce();
                write_reg(plan[r].reg_sel, plan[r].value[GAIN_W-1:0]);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                push_sample(plan[r].value, plan[r].typed, plan[r].want);
            end
        end

        // Random phases: new settings while idle, then a run of samples.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            quiesce();
            wrote = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                if ((k < 3 && $urandom_range(0, 2) != 0) || (k == 3 && $urandom_range(0, 7) == 0))
                begin
                    if (k == CFG_LENGTH)
                    begin
                        case ($urandom_range(0, 6))
                            0:       data = '0;
                            1:       data = GAIN_W'(MAX_DELAY);
                            2:       data = {13'($urandom), 13'h1FFF};
                            3:       data = GAIN_W'($urandom);
                            default: data = GAIN_W'($urandom_range(1, 40));
                        endcase
                    end
                    else
                    begin
                        case ($urandom_range(0, 5))
                            0:       data = '0;
                            1:       data = Q_ONE;
                            2:       data = '1;
                            4:       data = GAIN_W'($urandom);
                            default: data = GAIN_W'($urandom_range(0, 33554432));
                        endcase
                    end
                    write_reg(CFG_INDEX_W'(k), data);
                    wrote = 1'b1;
                end
            end
            if (wrote)
                cfg_valid <= 1'b0;
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       s = 32'h7FFFFFFF;
                    1:       s = 32'h80000000;
                    2:       s = 32'h00000000;
                    3:       s = 32'hFFFFFFFF;
                    4:       s = 32'($urandom_range(0, 255)) - 32'd128;
                    default: s = $urandom;
                endcase
                push_sample(s, 1'b0, '0);
            end
        end

        // Drain, let the pipeline settle, then report.
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && delayed_q.size() == 0)
            $display("lowpass_feedback_comb_filter_unit_tb: PASS");
        else
            $display("lowpass_feedback_comb_filter_unit_tb: FAIL");
        $finish;
    end

endmodule
